// ----- rtl/ybp_pkg.sv -----
package ybp_pkg;

	// Default precision of the conversion coefficients (fraction bits).
	localparam int FRAC_BITS_DEFAULT = 16;

	// Coefficients in units of 1e-4, turned into fixed point at elaboration.
	localparam int COEF_R_V_E4 = 14065;
	localparam int COEF_G_U_E4 = 3455;
	localparam int COEF_G_V_E4 = 7169;
	localparam int COEF_B_U_E4 = 11790;
	localparam int SCALE_E4    = 10000;
	localparam int ROUND_E4    = 5000;

	localparam int CHROMA_OFFSET = 128;
	localparam int CHAN_MAX      = 255;
	localparam int SAMPLE_W      = 8;
	localparam int DIFF_W        = SAMPLE_W + 1;

	localparam int IN_DATA_W  = 4 * SAMPLE_W;
	localparam int OUT_DATA_W = 6 * SAMPLE_W;

	// Per-stage load enables, from the handshake logic to the datapath.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// ----- rtl/yuyv_to_bgr_pair_converter_unit.sv -----
// YUYV 4:2:2 to BGR pixel-pair converter.
//
// Input stream (s_*): one YUYV word per transfer, two luma samples sharing
// one U and one V. Output stream (m_*): one transfer per input word, carrying
// the two BGR pixels, each channel saturated to 0..255 and truncated.
// Coefficients are fixed point with COEFF_FRAC_BITS fraction bits.
//
// Pipeline: the accepting edge loads the first of four register stages
// (offset, products, sums, saturation), and m_tvalid rises once the word has
// reached the saturation stage. Throughput: one word per cycle, sustained
// while m_tready stays high; the four stages hold up to four words in flight.
//
// Reset (arst_n low) empties the pipeline; data in flight is dropped and
// m_tvalid falls at once. When the receiver stalls, m_tdata holds; each stage
// keeps loading while the one ahead of it is empty or moving, so gaps close
// up and s_tready falls only once all four stages hold a word. s_tready
// is combinational in m_tready through the stage enables.
module yuyv_to_bgr_pair_converter_unit #(
	parameter int COEFF_FRAC_BITS = ybp_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata: luma_first, chroma_blue, luma_second, chroma_red (8 bits each)
	input  logic [ybp_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata: blue_first, green_first, red_first,
	//          blue_second, green_second, red_second (8 bits each)
	output logic [ybp_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int SW = ybp_pkg::SAMPLE_W;

	ybp_pkg::stage_en_t en;

	// valid bit for each stage
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// a stage loads when empty or when its contents move on
	always_comb begin
		en.s4 = !vld_s4 || m_tready;
		en.s3 = !vld_s3 || en.s4;
		en.s2 = !vld_s2 || en.s3;
		en.s1 = !vld_s1 || en.s2;
	end

	assign s_tready = en.s1;
	assign m_tvalid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= s_tvalid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
		end
	end

	logic [SW-1:0]                       luma_first_s2;
	logic [SW-1:0]                       luma_second_s2;
	logic signed [COEFF_FRAC_BITS+10:0]  r_v_s2;
	logic signed [COEFF_FRAC_BITS+10:0]  g_u_s2;
	logic signed [COEFF_FRAC_BITS+10:0]  g_v_s2;
	logic signed [COEFF_FRAC_BITS+10:0]  b_u_s2;

	ybp_chroma_terms #(
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS)
	) u_terms (
		.clk            (clk),
		.en             (en),
		.luma_first     (s_tdata[0*SW +: SW]),
		.chroma_blue    (s_tdata[1*SW +: SW]),
		.luma_second    (s_tdata[2*SW +: SW]),
		.chroma_red     (s_tdata[3*SW +: SW]),
		.luma_first_s2  (luma_first_s2),
		.luma_second_s2 (luma_second_s2),
		.r_v_s2         (r_v_s2),
		.g_u_s2         (g_u_s2),
		.g_v_s2         (g_v_s2),
		.b_u_s2         (b_u_s2)
	);

	// first pixel
	ybp_channel #(
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS)
	) u_pix_first (
		.clk   (clk),
		.en    (en),
		.luma  (luma_first_s2),
		.r_v   (r_v_s2),
		.g_u   (g_u_s2),
		.g_v   (g_v_s2),
		.b_u   (b_u_s2),
		.blue  (m_tdata[0*SW +: SW]),
		.green (m_tdata[1*SW +: SW]),
		.red   (m_tdata[2*SW +: SW])
	);

	// second pixel
	ybp_channel #(
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS)
	) u_pix_second (
		.clk   (clk),
		.en    (en),
		.luma  (luma_second_s2),
		.r_v   (r_v_s2),
		.g_u   (g_u_s2),
		.g_v   (g_v_s2),
		.b_u   (b_u_s2),
		.blue  (m_tdata[3*SW +: SW]),
		.green (m_tdata[4*SW +: SW]),
		.red   (m_tdata[5*SW +: SW])
	);

`ifndef SYNTHESIS
	// an empty first stage always takes a transfer
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_tready)
		else $error("first stage empty but s_tready low");

	// an accepted word lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s1)
		else $error("accepted transfer lost at stage 1");

	// a word in stage 3 moving on reaches the output
	a_s3_moves: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && en.s4 |=> m_tvalid)
		else $error("word lost between stage 3 and output");

	// a stalled output keeps the stage behind it full
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && m_tvalid && !m_tready |=> vld_s3)
		else $error("stage 3 dropped a word during stall");
`endif

endmodule

// ----- rtl/ybp_chroma_terms.sv -----
// Stage 1: register samples and remove the chroma offset.
// Stage 2: the four coefficient products.
module ybp_chroma_terms #(
	parameter int COEFF_FRAC_BITS = ybp_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                                     clk,
	input  ybp_pkg::stage_en_t                       en,
	input  logic [ybp_pkg::SAMPLE_W-1:0]             luma_first,
	input  logic [ybp_pkg::SAMPLE_W-1:0]             chroma_blue,
	input  logic [ybp_pkg::SAMPLE_W-1:0]             luma_second,
	input  logic [ybp_pkg::SAMPLE_W-1:0]             chroma_red,
	output logic [ybp_pkg::SAMPLE_W-1:0]             luma_first_s2,
	output logic [ybp_pkg::SAMPLE_W-1:0]             luma_second_s2,
	output logic signed [COEFF_FRAC_BITS+10:0]       r_v_s2,
	output logic signed [COEFF_FRAC_BITS+10:0]       g_u_s2,
	output logic signed [COEFF_FRAC_BITS+10:0]       g_v_s2,
	output logic signed [COEFF_FRAC_BITS+10:0]       b_u_s2
);

	localparam int COEF_W = COEFF_FRAC_BITS + 1;
	localparam int PROD_W = COEFF_FRAC_BITS + 11;

	localparam logic [63:0] COEF_R_V_WIDE =
		((64'(ybp_pkg::COEF_R_V_E4) << COEFF_FRAC_BITS) + 64'(ybp_pkg::ROUND_E4))
		/ 64'(ybp_pkg::SCALE_E4);
	localparam logic [63:0] COEF_G_U_WIDE =
		((64'(ybp_pkg::COEF_G_U_E4) << COEFF_FRAC_BITS) + 64'(ybp_pkg::ROUND_E4))
		/ 64'(ybp_pkg::SCALE_E4);
	localparam logic [63:0] COEF_G_V_WIDE =
		((64'(ybp_pkg::COEF_G_V_E4) << COEFF_FRAC_BITS) + 64'(ybp_pkg::ROUND_E4))
		/ 64'(ybp_pkg::SCALE_E4);
	localparam logic [63:0] COEF_B_U_WIDE =
		((64'(ybp_pkg::COEF_B_U_E4) << COEFF_FRAC_BITS) + 64'(ybp_pkg::ROUND_E4))
		/ 64'(ybp_pkg::SCALE_E4);

	// Zero-extended by one bit so the products are signed.
	localparam logic signed [COEF_W:0] COEF_R_V = {1'b0, COEF_R_V_WIDE[COEF_W-1:0]};
	localparam logic signed [COEF_W:0] COEF_G_U = {1'b0, COEF_G_U_WIDE[COEF_W-1:0]};
	localparam logic signed [COEF_W:0] COEF_G_V = {1'b0, COEF_G_V_WIDE[COEF_W-1:0]};
	localparam logic signed [COEF_W:0] COEF_B_U = {1'b0, COEF_B_U_WIDE[COEF_W-1:0]};

	localparam logic [ybp_pkg::DIFF_W-1:0] OFFSET = ybp_pkg::DIFF_W'(ybp_pkg::CHROMA_OFFSET);

	logic [ybp_pkg::SAMPLE_W-1:0]      luma_first_s1;
	logic [ybp_pkg::SAMPLE_W-1:0]      luma_second_s1;
	logic signed [ybp_pkg::DIFF_W-1:0] du_s1;
	logic signed [ybp_pkg::DIFF_W-1:0] dv_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			luma_first_s1  <= luma_first;
			luma_second_s1 <= luma_second;
			du_s1          <= $signed({1'b0, chroma_blue} - OFFSET);
			dv_s1          <= $signed({1'b0, chroma_red} - OFFSET);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			luma_first_s2  <= luma_first_s1;
			luma_second_s2 <= luma_second_s1;
			r_v_s2         <= PROD_W'(COEF_R_V * dv_s1);
			g_u_s2         <= PROD_W'(COEF_G_U * du_s1);
			g_v_s2         <= PROD_W'(COEF_G_V * dv_s1);
			b_u_s2         <= PROD_W'(COEF_B_U * du_s1);
		end
	end

endmodule

// ----- rtl/ybp_channel.sv -----
// One output pixel. Stage 3: luma plus chroma terms. Stage 4: saturate, truncate.
module ybp_channel #(
	parameter int COEFF_FRAC_BITS = ybp_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                               clk,
	input  ybp_pkg::stage_en_t                 en,
	input  logic [ybp_pkg::SAMPLE_W-1:0]       luma,
	input  logic signed [COEFF_FRAC_BITS+10:0] r_v,
	input  logic signed [COEFF_FRAC_BITS+10:0] g_u,
	input  logic signed [COEFF_FRAC_BITS+10:0] g_v,
	input  logic signed [COEFF_FRAC_BITS+10:0] b_u,
	output logic [ybp_pkg::SAMPLE_W-1:0]       blue,
	output logic [ybp_pkg::SAMPLE_W-1:0]       green,
	output logic [ybp_pkg::SAMPLE_W-1:0]       red
);

	localparam int ACC_W = COEFF_FRAC_BITS + 11;
	localparam logic signed [ACC_W-1:0] TOP =
		ACC_W'(ybp_pkg::CHAN_MAX) <<< COEFF_FRAC_BITS;

	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] blue_acc_s3;
	logic signed [ACC_W-1:0] green_acc_s3;
	logic signed [ACC_W-1:0] red_acc_s3;

	assign base = $signed(ACC_W'(luma)) <<< COEFF_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			blue_acc_s3  <= base + b_u;
			green_acc_s3 <= base - g_u - g_v;
			red_acc_s3   <= base + r_v;
		end
	end

	function automatic logic [ybp_pkg::SAMPLE_W-1:0] clamp(input logic signed [ACC_W-1:0] acc);
		logic [ybp_pkg::SAMPLE_W-1:0] res;
		if (acc < 0) begin
			res = '0;
		end else if (acc >= TOP) begin
			res = ybp_pkg::SAMPLE_W'(ybp_pkg::CHAN_MAX);
		end else begin
			res = acc[COEFF_FRAC_BITS +: ybp_pkg::SAMPLE_W];
		end
		return res;
	endfunction

	always_ff @(posedge clk) begin
		if (en.s4) begin
			blue  <= clamp(blue_acc_s3);
			green <= clamp(green_acc_s3);
			red   <= clamp(red_acc_s3);
		end
	end

endmodule
